// ===== hdl/owsm_pkg.sv =====
// Shared types and constants for the omni base wheel speed mixer.
// Used by every module under hdl; depends on nothing.
package owsm_pkg;

    localparam int ANG_W       = 16;
    localparam int SIN_W       = 16;
    localparam int FRONT_LAT   = 5;
    localparam int FLIGHT_W    = 3;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = 3;
    localparam int FIFO_CNT_W  = 4;
    localparam int RAW_W       = 46;
    localparam int MAG_W       = 45;
    localparam int NUM_W       = 52;
    localparam int QUO_W       = 7;
    localparam int SPEED_W     = 8;
    localparam int CFG_ADDR_W  = 2;

    // sine polynomial coefficients, Q14
    localparam logic [13:0] SIN_C1 = 14'd10512;
    localparam logic [10:0] SIN_C2 = 11'd1160;
    localparam logic [14:0] SIN_C0 = 15'd25736;
    localparam logic [14:0] QUARTER = 15'd16384;
    localparam logic [15:0] COS_SHIFT = 16'h4000;
    localparam logic [6:0]  FULL_SCALE = 7'd100;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_WHEEL_TWO   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WHEEL_THREE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TURN_GAIN   = 2'd2;

    // reset values of the registers
    localparam logic [15:0] WHEEL_TWO_RST   = 16'd21845;
    localparam logic [15:0] WHEEL_THREE_RST = 16'd43691;
    localparam logic [15:0] TURN_GAIN_RST   = 16'd18446;

    // one classified command as it leaves the front end
    typedef struct packed {
        logic [2:0][SIN_W-1:0] sin_a;
        logic [2:0][SIN_W-1:0] cos_a;
        logic [SIN_W-1:0]      cos_h;
        logic signed [15:0]    move_x;
        logic signed [15:0]    move_y;
        logic signed [15:0]    turn_rate;
        logic                  idle_cmd;
    } front_item_t;

endpackage

// ===== hdl/omni_base_wheel_speed_mixer_unit.sv =====
// Pipeline: 19 register stages from the accepting edge to m_tvalid, the first
// loaded on that edge: 5 front sine stages, one queue stage, 13 back stages.
// Throughput: one beat per cycle while s_tready is high; the queue of 8 entries and the
// front pipeline depth set the credit that gates s_tready. No clearing pass after reset.
// Reset (aresetn, synchronous, low) empties the pipeline and queue and loads
// the register reset values.
module omni_base_wheel_speed_mixer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // heading, move_x, move_y, turn_rate
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // wheel_one_speed, wheel_two_speed, wheel_three_speed
    output logic        m_tuser,   // stopped
    input  logic        cfg_wr_en,
    input  logic [owsm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import owsm_pkg::*;

    logic [15:0]           wheel_two_reg, wheel_three_reg, gain_reg;
    logic                  front_v, head_v, back_rdy, accept;
    front_item_t           front_item, head_item;
    logic [FLIGHT_W-1:0]   flight;
    logic [FIFO_CNT_W-1:0] fifo_cnt;
    logic [FIFO_CNT_W:0]   credit_used;

    // write registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wheel_two_reg   <= WHEEL_TWO_RST;
            wheel_three_reg <= WHEEL_THREE_RST;
            gain_reg        <= TURN_GAIN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_WHEEL_TWO:   wheel_two_reg   <= cfg_wdata;
                CFG_WHEEL_THREE: wheel_three_reg <= cfg_wdata;
                CFG_TURN_GAIN:   gain_reg        <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // accept only while every beat in flight has a queue slot
    assign credit_used = {1'b0, fifo_cnt} + (FIFO_CNT_W+1)'(flight);
    assign s_tready    = credit_used < (FIFO_CNT_W+1)'(FIFO_DEPTH);
    assign accept      = s_tvalid && s_tready;

    owsm_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(accept),
        .heading(s_tdata[15:0]), .move_x($signed(s_tdata[31:16])),
        .move_y($signed(s_tdata[47:32])), .turn_rate($signed(s_tdata[63:48])),
        .wheel_two_angle(wheel_two_reg), .wheel_three_angle(wheel_three_reg),
        .out_valid(front_v), .out_item(front_item), .flight(flight)
    );

    owsm_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn), .push(front_v), .push_item(front_item),
        .pop(back_rdy), .head_valid(head_v), .head_item(head_item), .count(fifo_cnt)
    );

    owsm_back u_back (
        .aclk(aclk), .aresetn(aresetn), .in_valid(head_v), .in_item(head_item),
        .in_ready(back_rdy), .turn_gain(gain_reg), .m_tvalid(m_tvalid),
        .m_tready(m_tready), .speed_one(m_tdata[7:0]), .speed_two(m_tdata[15:8]),
        .speed_three(m_tdata[23:16]), .stopped(m_tuser)
    );

endmodule

// ===== hdl/owsm_sin.sv =====
// Five-stage fixed-point sine of a 16-bit binary angle, Q14 result.
// Uses owsm_pkg; one lane, free running.
module owsm_sin (
    input  logic                        aclk,
    input  logic [owsm_pkg::ANG_W-1:0]  angle,
    output logic [owsm_pkg::SIN_W-1:0]  sin_val
);
    import owsm_pkg::*;

    logic [14:0] x1_reg, x2s_reg, x3_reg, x4_reg;
    logic        neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic [14:0] sq2_reg, sq3_reg;
    logic [13:0] t1_reg;
    logic [14:0] t2_reg;
    logic [15:0] sin_reg;

    logic [14:0] x1_next;
    logic [29:0] sq_full;
    logic [24:0] c2_full;
    logic [28:0] t1p_full;
    logic [29:0] m_full;
    logic [15:0] m_val;

    // fold the angle into the first quadrant and form the stage products
    always_comb begin
        x1_next  = angle[14] ? (QUARTER - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
        sq_full  = x1_reg * x1_reg;
        c2_full  = sq2_reg * SIN_C2;
        t1p_full = sq3_reg * t1_reg;
        m_full   = x4_reg * t2_reg;
        m_val    = m_full[29:14];
    end

    always_ff @(posedge aclk) begin
        x1_reg   <= x1_next;
        neg1_reg <= angle[15];
        sq2_reg  <= sq_full[28:14];
        x2s_reg  <= x1_reg;
        neg2_reg <= neg1_reg;
        t1_reg   <= SIN_C1 - {3'b0, c2_full[24:14]};
        sq3_reg  <= sq2_reg;
        x3_reg   <= x2s_reg;
        neg3_reg <= neg2_reg;
        t2_reg   <= SIN_C0 - t1p_full[28:14];
        x4_reg   <= x3_reg;
        neg4_reg <= neg3_reg;
        sin_reg  <= neg4_reg ? (16'd0 - m_val) : m_val;
    end

    assign sin_val = sin_reg;

endmodule

// ===== hdl/owsm_front.sv =====
// Front end: wheel angles and all sines and cosines for one command.
// Uses owsm_pkg and seven owsm_sin lanes; never stalls.
module owsm_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    input  logic [15:0]                    heading,
    input  logic signed [15:0]             move_x,
    input  logic signed [15:0]             move_y,
    input  logic signed [15:0]             turn_rate,
    input  logic [15:0]                    wheel_two_angle,
    input  logic [15:0]                    wheel_three_angle,
    output logic                           out_valid,
    output owsm_pkg::front_item_t          out_item,
    output logic [owsm_pkg::FLIGHT_W-1:0]  flight
);
    import owsm_pkg::*;

    logic [FRONT_LAT-1:0] vld_reg;
    logic signed [15:0]   mx_reg [FRONT_LAT];
    logic signed [15:0]   my_reg [FRONT_LAT];
    logic signed [15:0]   tr_reg [FRONT_LAT];
    logic                 idle_reg [FRONT_LAT];
    logic [2:0][15:0]     ang;
    logic [2:0][15:0]     sin_w, cos_w;
    logic [15:0]          cos_h_w;
    logic [FLIGHT_W-1:0]  flight_sum;

    // wheel angles wrap modulo a full turn
    assign ang[0] = heading;
    assign ang[1] = heading + wheel_two_angle;
    assign ang[2] = heading + wheel_three_angle;

    for (genvar i = 0; i < 3; i++) begin : g_lane
        owsm_sin u_sin (.aclk(aclk), .angle(ang[i]), .sin_val(sin_w[i]));
        owsm_sin u_cos (.aclk(aclk), .angle(ang[i] + COS_SHIFT), .sin_val(cos_w[i]));
    end
    owsm_sin u_cos_h (.aclk(aclk), .angle(heading + COS_SHIFT), .sin_val(cos_h_w));

    // advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[FRONT_LAT-2:0], in_valid};
        end
    end

    // carry the motion fields and the idle flag alongside the sine lanes
    always_ff @(posedge aclk) begin
        mx_reg[0]   <= move_x;
        my_reg[0]   <= move_y;
        tr_reg[0]   <= turn_rate;
        idle_reg[0] <= (heading == 16'd0) && (move_x == 16'sd0) && (move_y == 16'sd0)
                       && (turn_rate == 16'sd0);
        for (int s = 1; s < FRONT_LAT; s++) begin
            mx_reg[s]   <= mx_reg[s-1];
            my_reg[s]   <= my_reg[s-1];
            tr_reg[s]   <= tr_reg[s-1];
            idle_reg[s] <= idle_reg[s-1];
        end
    end

    always_comb begin
        flight_sum = '0;
        for (int s = 0; s < FRONT_LAT; s++) begin
            flight_sum = flight_sum + FLIGHT_W'(vld_reg[s]);
        end
    end

    assign flight             = flight_sum;
    assign out_valid          = vld_reg[FRONT_LAT-1];
    assign out_item.sin_a     = sin_w;
    assign out_item.cos_a     = cos_w;
    assign out_item.cos_h     = cos_h_w;
    assign out_item.move_x    = mx_reg[FRONT_LAT-1];
    assign out_item.move_y    = my_reg[FRONT_LAT-1];
    assign out_item.turn_rate = tr_reg[FRONT_LAT-1];
    assign out_item.idle_cmd  = idle_reg[FRONT_LAT-1];

endmodule

// ===== hdl/owsm_fifo.sv =====
// Short queue between front end and back end.
// Uses owsm_pkg; register storage, one read address.
module owsm_fifo (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             push,
    input  owsm_pkg::front_item_t            push_item,
    input  logic                             pop,
    output logic                             head_valid,
    output owsm_pkg::front_item_t            head_item,
    output logic [owsm_pkg::FIFO_CNT_W-1:0]  count
);
    import owsm_pkg::*;

    front_item_t          mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] cnt_reg;
    logic                 do_pop;

    assign do_pop = pop && (cnt_reg != '0);

    // hold the payload
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(do_pop);
        end
    end

    assign head_valid = (cnt_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];
    assign count      = cnt_reg;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (cnt_reg < FIFO_CNT_W'(FIFO_DEPTH)) || do_pop)
        else $error("queue overflow");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !do_pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count slip");
`endif

endmodule

// ===== hdl/owsm_back.sv =====
// Back end: raw wheel speeds, largest magnitude, scaling to percent.
// Uses owsm_pkg; pipeline with a shared stall, restoring divide one bit a stage.
module owsm_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  owsm_pkg::front_item_t         in_item,
    output logic                          in_ready,
    input  logic [15:0]                   turn_gain,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [owsm_pkg::SPEED_W-1:0]  speed_one,
    output logic [owsm_pkg::SPEED_W-1:0]  speed_two,
    output logic [owsm_pkg::SPEED_W-1:0]  speed_three,
    output logic                          stopped
);
    import owsm_pkg::*;

    logic en;

    // stage b0: sine times cosine, gain times turn
    logic                 v0_reg;
    logic signed [29:0]   pa_reg [3];
    logic signed [29:0]   pc_reg [3];
    logic signed [32:0]   tg_reg;
    logic signed [15:0]   mx_reg, my_reg;
    logic                 idle0_reg;
    // stage b1: times motion
    logic                 v1_reg;
    logic signed [45:0]   px_reg [3];
    logic signed [45:0]   py_reg [3];
    logic signed [45:0]   turn_reg;
    logic                 idle1_reg;
    // stage b2: raw speeds
    logic                 v2_reg;
    logic signed [RAW_W-1:0] raw_reg [3];
    logic                 idle2_reg;
    // stage b3: magnitudes
    logic                 v3_reg;
    logic [MAG_W-1:0]     mag_reg [3];
    logic [2:0]           neg3_reg;
    logic                 stop3_reg;
    // stage b4: largest magnitude, scaled numerators
    logic                 v4_reg;
    logic [MAG_W-1:0]     top_reg;
    logic [NUM_W-1:0]     num_reg [3];
    logic [2:0]           neg4_reg;
    logic                 stop4_reg;
    // divide stages
    logic                 dv_v_reg   [QUO_W];
    logic [NUM_W-1:0]     dv_rem_reg [QUO_W][3];
    logic [QUO_W-1:0]     dv_quo_reg [QUO_W][3];
    logic [MAG_W-1:0]     dv_top_reg [QUO_W];
    logic [2:0]           dv_neg_reg [QUO_W];
    logic                 dv_stop_reg[QUO_W];
    logic [NUM_W-1:0]     dv_rem_next [QUO_W][3];
    logic [QUO_W-1:0]     dv_quo_next [QUO_W][3];
    // output register
    logic                 out_v_reg;
    logic [SPEED_W-1:0]   out_spd_reg [3];
    logic                 out_stop_reg;

    logic signed [31:0]   pa_full [3];
    logic signed [31:0]   pc_full [3];
    logic signed [32:0]   tg_full;
    logic signed [45:0]   raw_full [3];
    logic signed [45:0]   mag_full [3];
    logic [MAG_W-1:0]     top_a, top_next;
    logic [NUM_W-1:0]     num_full [3];
    logic [SPEED_W-1:0]   spd_next [3];

    assign en       = !out_v_reg || m_tready;
    assign in_ready = en;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pa_full[i]  = $signed(in_item.sin_a[i]) * $signed(in_item.cos_h);
            pc_full[i]  = $signed(in_item.cos_a[i]) * $signed(in_item.cos_h);
            raw_full[i] = py_reg[i] - px_reg[i] + turn_reg;
            mag_full[i] = raw_reg[i][RAW_W-1] ? -raw_reg[i] : raw_reg[i];
            num_full[i] = {7'b0, mag_reg[i]} * NUM_W'(FULL_SCALE);
        end
        tg_full  = $signed({1'b0, turn_gain}) * in_item.turn_rate;
        top_a    = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
        top_next = (mag_reg[2] > top_a) ? mag_reg[2] : top_a;
    end

    // one quotient bit per divide stage, most significant first
    always_comb begin
        for (int s = 0; s < QUO_W; s++) begin
            for (int i = 0; i < 3; i++) begin
                logic [NUM_W-1:0] rem_in;
                logic [NUM_W-1:0] quo_in_x;
                logic [NUM_W-1:0] dvs;
                rem_in   = (s == 0) ? num_reg[i] : dv_rem_reg[(s == 0) ? 0 : s-1][i];
                quo_in_x = (s == 0) ? '0 : NUM_W'(dv_quo_reg[(s == 0) ? 0 : s-1][i]);
                dvs      = NUM_W'((s == 0) ? top_reg : dv_top_reg[(s == 0) ? 0 : s-1])
                           << (QUO_W - 1 - s);
                if (rem_in >= dvs) begin
                    dv_rem_next[s][i] = rem_in - dvs;
                    dv_quo_next[s][i] = quo_in_x[QUO_W-1:0]
                                        | (QUO_W'(1) << (QUO_W - 1 - s));
                end else begin
                    dv_rem_next[s][i] = rem_in;
                    dv_quo_next[s][i] = quo_in_x[QUO_W-1:0];
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            spd_next[i] = dv_neg_reg[QUO_W-1][i]
                          ? (SPEED_W'(0) - {1'b0, dv_quo_reg[QUO_W-1][i]})
                          : {1'b0, dv_quo_reg[QUO_W-1][i]};
            if (dv_stop_reg[QUO_W-1]) begin
                spd_next[i] = '0;
            end
        end
    end

    // advance valid bits on the shared enable
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            out_v_reg <= 1'b0;
            for (int s = 0; s < QUO_W; s++) begin
                dv_v_reg[s] <= 1'b0;
            end
        end else if (en) begin
            v0_reg      <= in_valid;
            v1_reg      <= v0_reg;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            dv_v_reg[0] <= v4_reg;
            for (int s = 1; s < QUO_W; s++) begin
                dv_v_reg[s] <= dv_v_reg[s-1];
            end
            out_v_reg   <= dv_v_reg[QUO_W-1];
        end
    end

    // advance the payload
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                pa_reg[i]      <= pa_full[i][29:0];
                pc_reg[i]      <= pc_full[i][29:0];
                px_reg[i]      <= pa_reg[i] * mx_reg;
                py_reg[i]      <= pc_reg[i] * my_reg;
                raw_reg[i]     <= raw_full[i];
                mag_reg[i]     <= mag_full[i][MAG_W-1:0];
                neg3_reg[i]    <= raw_reg[i][RAW_W-1];
                num_reg[i]     <= num_full[i];
                out_spd_reg[i] <= spd_next[i];
            end
            tg_reg    <= tg_full;
            mx_reg    <= in_item.move_x;
            my_reg    <= in_item.move_y;
            idle0_reg <= in_item.idle_cmd;
            turn_reg  <= {tg_reg[32], tg_reg, 12'b0};
            idle1_reg <= idle0_reg;
            idle2_reg <= idle1_reg;
            stop3_reg <= idle2_reg || ((raw_reg[0] == '0) && (raw_reg[1] == '0)
                                       && (raw_reg[2] == '0));
            top_reg   <= top_next;
            neg4_reg  <= neg3_reg;
            stop4_reg <= stop3_reg;
            for (int s = 0; s < QUO_W; s++) begin
                for (int i = 0; i < 3; i++) begin
                    dv_rem_reg[s][i] <= dv_rem_next[s][i];
                    dv_quo_reg[s][i] <= dv_quo_next[s][i];
                end
                dv_top_reg[s]  <= (s == 0) ? top_reg   : dv_top_reg[(s == 0) ? 0 : s-1];
                dv_neg_reg[s]  <= (s == 0) ? neg4_reg  : dv_neg_reg[(s == 0) ? 0 : s-1];
                dv_stop_reg[s] <= (s == 0) ? stop4_reg : dv_stop_reg[(s == 0) ? 0 : s-1];
            end
            out_stop_reg <= dv_stop_reg[QUO_W-1];
        end
    end

    assign m_tvalid    = out_v_reg;
    assign speed_one   = out_spd_reg[0];
    assign speed_two   = out_spd_reg[1];
    assign speed_three = out_spd_reg[2];
    assign stopped     = out_stop_reg;

`ifndef SYNTHESIS
    a_stop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && stopped) |-> (speed_one == '0 && speed_two == '0 && speed_three == '0))
        else $error("stopped result carries a speed");
    a_full_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !stopped) |->
            (speed_one == 8'd100 || speed_one == 8'h9C || speed_two == 8'd100
             || speed_two == 8'h9C || speed_three == 8'd100 || speed_three == 8'h9C))
        else $error("no wheel at full scale");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(speed_one) && $stable(stopped))
        else $error("stalled result changed");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for omni_base_wheel_speed_mixer_unit: drives motion commands,
// predicts wheel speeds from its own fixed-point kinematics and compares results.
// Depends on owsm_pkg and the unit under test.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import owsm_pkg::*;

    typedef struct packed {
        logic signed [7:0] w1;
        logic signed [7:0] w2;
        logic signed [7:0] w3;
        logic              stopped;
    } speeds_t;

    class speed_scoreboard;
        speeds_t pending[$];
        int      errors;
        logic [15:0] two_ang, three_ang, gain;

        function void reset_regs();
            two_ang = WHEEL_TWO_RST;
            three_ang = WHEEL_THREE_RST;
            gain = TURN_GAIN_RST;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [15:0] val);
            case (idx)
                CFG_WHEEL_TWO:   two_ang = val;
                CFG_WHEEL_THREE: three_ang = val;
                CFG_TURN_GAIN:   gain = val;
                default: ;
            endcase
        endfunction

        function longint sine_q14(logic [15:0] a);
            longint x, x2, t1, t2, m;
            x = a[14] ? 16384 - a[13:0] : a[13:0];
            x2 = (x * x) >>> 14;
            t1 = 10512 - ((1160 * x2) >>> 14);
            t2 = 25736 - ((x2 * t1) >>> 14);
            m = (x * t2) >>> 14;
            return a[15] ? -m : m;
        endfunction

        function longint cosine_q14(logic [15:0] a);
            logic [15:0] b;
            b = a + 16'h4000;
            return sine_q14(b);
        endfunction

        // note an accepted command and queue its wheel speeds
        function void note_command(logic [63:0] d);
            logic [15:0] h, ang;
            longint mx, my, tr, ch, turn, top, r[3], mg;
            speeds_t e;
            h = d[15:0];
            mx = $signed(d[31:16]);
            my = $signed(d[47:32]);
            tr = $signed(d[63:48]);
            e = '{0, 0, 0, 1'b1};
            if (d != 0) begin
                ch = cosine_q14(h);
                turn = longint'(gain) * tr * 4096;
                top = 0;
                for (int i = 0; i < 3; i++) begin
                    ang = h + (i == 0 ? 16'd0 : (i == 1 ? two_ang : three_ang));
                    r[i] = -(sine_q14(ang) * ch) * mx + (cosine_q14(ang) * ch) * my + turn;
                    mg = r[i] < 0 ? -r[i] : r[i];
                    if (mg > top) top = mg;
                end
                if (top != 0) begin
                    for (int i = 0; i < 3; i++) begin
                        mg = ((r[i] < 0 ? -r[i] : r[i]) * 100) / top;
                        if (r[i] < 0) mg = -mg;
                        if (i == 0) e.w1 = mg[7:0];
                        else if (i == 1) e.w2 = mg[7:0];
                        else e.w3 = mg[7:0];
                    end
                    e.stopped = 1'b0;
                end
            end
            pending.push_back(e);
        endfunction

        task report(string what, int got, int want);
            $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
            errors++;
        endtask

        // compare one result beat with the oldest expectation
        task check_result(logic [23:0] d, logic stp);
            speeds_t e;
            if (pending.size() == 0) begin
                report("unexpected beat", 1, 0);
                return;
            end
            e = pending.pop_front();
            if ($signed(d[7:0]) != e.w1) report("wheel_one_speed", $signed(d[7:0]), e.w1);
            if ($signed(d[15:8]) != e.w2) report("wheel_two_speed", $signed(d[15:8]), e.w2);
            if ($signed(d[23:16]) != e.w3)
                report("wheel_three_speed", $signed(d[23:16]), e.w3);
            if (stp != e.stopped) report("stopped", stp, e.stopped);
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // heading, move_x, move_y, turn_rate
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // wheel_one_speed, wheel_two_speed, wheel_three_speed
    logic        m_tuser;        // stopped
    logic        cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = CFG_WHEEL_TWO;
    logic [15:0] cfg_wdata = '0;

    speed_scoreboard board = new();
    bit calm_window = 0;
    int quiet_cycles = 0;
    localparam int WATCHDOG = 5000;
    // index with no register behind it
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

    omni_base_wheel_speed_mixer_unit uut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // sample both channels at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) board.note_command(s_tdata);
            if (m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // receiver stalls at random outside the calm window
    always @(negedge aclk) begin
        m_tready <= calm_window || ($urandom_range(99) >= 13);
    end

    // present one command and hold it until accepted; valid stays high for the next
    task send_command(logic [15:0] h, logic [15:0] mx, logic [15:0] my, logic [15:0] tr);
        while (!calm_window && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {tr, my, mx, h};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task drain_results();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (25) @(negedge aclk);
    endtask

    // present one register write; the caller drops the enable after a group
    task write_register(logic [CFG_ADDR_W-1:0] idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        board.write_reg(idx, val);
        @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_field();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'(signed'($urandom_range(40)) - 20);
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        logic [15:0] settings[4][3];
        settings = '{'{WHEEL_TWO_RST, WHEEL_THREE_RST, TURN_GAIN_RST},
                     '{16'h0000, 16'h0000, 16'h0000},
                     '{16'hFFFF, 16'hFFFF, 16'hFFFF},
                     '{16'h4000, 16'hC000, 16'h0001}};
        board.reset_regs();
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: extremes, all-zero command, zero raw speeds
        send_command(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_command(16'h0000, 16'h0000, 16'h0000, 16'h0001);
        send_command(16'h4000, 16'h7FFF, 16'h7FFF, 16'h0000);   // cos(h)=0, no turn
        send_command(16'hFFFF, 16'h8000, 16'h8000, 16'h8000);
        send_command(16'h0000, 16'h7FFF, 16'h0000, 16'h0000);
        send_command(16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
        send_command(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
        send_command(16'hC000, 16'h0001, 16'hFFFF, 16'h0000);
        send_command(16'h2000, 16'h1234, 16'hEDCB, 16'h0100);
        send_command(16'h0001, 16'h0000, 16'h0000, 16'h0000);
        // pause until every expected result is back
        drain_results();

        // random phases across register settings, extremes included
        for (int p = 0; p < 6; p++) begin
            if (p < 4) begin
                write_register(CFG_WHEEL_TWO, settings[p][0]);
                write_register(CFG_WHEEL_THREE, settings[p][1]);
                write_register(CFG_TURN_GAIN, settings[p][2]);
            end else begin
                write_register(CFG_WHEEL_TWO, 16'($urandom()));
                write_register(CFG_WHEEL_THREE, 16'($urandom()));
                write_register(CFG_TURN_GAIN, 16'($urandom()));
                write_register(CFG_SPARE, 16'($urandom()));
            end
            cfg_wr_en <= 1'b0;
            calm_window = (p == 2);
            for (int n = 0; n < 280; n++) begin
                if ($urandom_range(49) == 0) send_command(16'h0000, 16'h0000, 16'h0000, 16'h0000);
                else send_command(16'($urandom()), pick_field(), pick_field(), pick_field());
            end
            calm_window = 0;
            drain_results();
        end

        if (board.errors == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule
